@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL of the sorted key map, used by its top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every clock edge outside reset
`define SKM_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that a consequent holds in the same cycle as its antecedent
`define SKM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that a consequent holds in the cycle after its antecedent
`define SKM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SKM_ASSERT_ALWAYS(label, clk, rst, expr)
`define SKM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SKM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/skm_pkg.sv @@
// Types, constants and codes shared by the sorted key map modules
package skm_pkg;

   // Table size and derived widths
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Payload widths
   localparam int FUNC_W = 2;
   localparam int KEY_W  = 16;
   localparam int ID_W   = 16;
   localparam int DATA_W = 16;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   // One stored mapping
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [ID_W-1:0]   id;
      logic [DATA_W-1:0] data;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_CHECK,
      ST_INS_MOVE,
      ST_LK_CHECK,
      ST_LK_CMP,
      ST_FINISH
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_req;
      logic res_clear;
      logic res_set_full;
      logic res_set_hit;
      logic idx_load;
      logic idx_dec;
      logic rd_ins;
      logic rd_lk;
      logic ins_write_old;
      logic ins_write_new;
      logic count_inc;
      logic count_clear;
      logic lk_init;
      logic lk_right;
      logic lk_left;
      logic out_load;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              key_zero;
      logic              count_full;
      logic [CNT_W-1:0]  count;
      logic              idx_zero;
      logic              rd_key_ge;
      logic              rd_key_eq;
      logic              rd_key_lt;
      logic              lk_open;
      logic              out_free;
   } sts_type;

endpackage

@@ rtl/core/skm_if.sv @@
// Request and response channel interfaces of the sorted key map

// Request channel: operation and mapping fields
interface skm_req_if;
   import skm_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [KEY_W-1:0]  key_code;
   logic [ID_W-1:0]   entry_id;
   logic [DATA_W-1:0] entry_data;
   logic [DATA_W-1:0] event_param;

   modport source (
      output valid, func, key_code, entry_id, entry_data, event_param,
      input  ready
   );
   modport sink (
      input  valid, func, key_code, entry_id, entry_data, event_param,
      output ready
   );
endinterface

// Response channel: one result per request
interface skm_rsp_if;
   import skm_pkg::*;

   logic              valid;
   logic              ready;
   logic              found;
   logic              table_full;
   logic [ID_W-1:0]   hit_id;
   logic [DATA_W-1:0] hit_data;
   logic [DATA_W-1:0] merged_value;

   modport source (
      output valid, found, table_full, hit_id, hit_data, merged_value,
      input  ready
   );
   modport sink (
      input  valid, found, table_full, hit_id, hit_data, merged_value,
      output ready
   );
endinterface

@@ rtl/core/skm_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module skm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/skm_datapath.sv @@
// Datapath of the sorted key map: request latch, table RAM, search and output registers
module skm_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  skm_pkg::cmd_type          cmd,
   output skm_pkg::sts_type          sts,
   input  logic [skm_pkg::FUNC_W-1:0] req_func,
   input  logic [skm_pkg::KEY_W-1:0]  req_key_code,
   input  logic [skm_pkg::ID_W-1:0]   req_entry_id,
   input  logic [skm_pkg::DATA_W-1:0] req_entry_data,
   input  logic [skm_pkg::DATA_W-1:0] req_event_param,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_found,
   output logic                      rsp_table_full,
   output logic [skm_pkg::ID_W-1:0]   rsp_hit_id,
   output logic [skm_pkg::DATA_W-1:0] rsp_hit_data,
   output logic [skm_pkg::DATA_W-1:0] rsp_merged_value
);
   import skm_pkg::*;

   // Latched request
   logic [FUNC_W-1:0] func_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [ID_W-1:0]   id_ff;
   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] param_ff;

   // Table control
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] idx_prev;
   logic [CNT_W-1:0] lo_ff;
   logic [CNT_W-1:0] end_ff;
   logic [CNT_W:0]   mid_sum;
   logic [CNT_W-1:0] mid;

   // Result and output registers
   logic              res_found_ff;
   logic              res_full_ff;
   logic [ID_W-1:0]   res_id_ff;
   logic [DATA_W-1:0] res_data_ff;
   logic [DATA_W-1:0] res_merged_ff;
   logic              out_valid_ff;
   logic              out_found_ff;
   logic              out_full_ff;
   logic [ID_W-1:0]   out_id_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic [DATA_W-1:0] out_merged_ff;

   // RAM ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_entry;
   entry_type         new_entry;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   entry_type         rd_entry;

   // Latch the request on transfer
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff  <= req_func;
         key_ff   <= req_key_code;
         id_ff    <= req_entry_id;
         data_ff  <= req_entry_data;
         param_ff <= req_event_param;
      end
   end

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.count_clear) begin
         count_ff <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // Insert cursor: walks down from the free slot above the top entry while shifting
   always_ff @(posedge clock) begin
      if (cmd.idx_load) begin
         idx_ff <= count_ff;
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_prev;
      end
   end

   assign idx_prev = idx_ff - CNT_W'(1);

   // Search window, end exclusive; midpoint rounds down
   always_ff @(posedge clock) begin
      if (cmd.lk_init) begin
         lo_ff  <= '0;
         end_ff <= count_ff;
      end else if (cmd.lk_right) begin
         lo_ff <= mid + CNT_W'(1);
      end else if (cmd.lk_left) begin
         end_ff <= mid;
      end
   end

   assign mid_sum = {1'b0, lo_ff} + {1'b0, end_ff} - (CNT_W+1)'(1);
   assign mid     = mid_sum[CNT_W:1];

   // Table RAM: old entry moves up one place, or new entry lands in its slot
   assign new_entry = '{key: key_ff, id: id_ff, data: data_ff};
   assign wr_en     = cmd.ins_write_old | cmd.ins_write_new;
   assign wr_addr   = idx_ff[ADDR_W-1:0];
   assign wr_entry  = cmd.ins_write_new ? new_entry : rd_entry;
   assign rd_en     = cmd.rd_ins | cmd.rd_lk;
   assign rd_addr   = cmd.rd_lk ? mid[ADDR_W-1:0] : idx_prev[ADDR_W-1:0];

   skm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // Result register: clear at decode, raising the full flag for a dropped insert
   always_ff @(posedge clock) begin
      if (cmd.res_clear) begin
         res_found_ff  <= 1'b0;
         res_full_ff   <= cmd.res_set_full;
         res_id_ff     <= '0;
         res_data_ff   <= '0;
         res_merged_ff <= '0;
      end else if (cmd.res_set_hit) begin
         res_found_ff  <= 1'b1;
         res_id_ff     <= rd_entry.id;
         res_data_ff   <= rd_entry.data;
         res_merged_ff <= rd_entry.data | param_ff;
      end
   end

   // Output register: hold until the response transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_found_ff  <= res_found_ff;
         out_full_ff   <= res_full_ff;
         out_id_ff     <= res_id_ff;
         out_data_ff   <= res_data_ff;
         out_merged_ff <= res_merged_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_found        = out_found_ff;
   assign rsp_table_full   = out_full_ff;
   assign rsp_hit_id       = out_id_ff;
   assign rsp_hit_data     = out_data_ff;
   assign rsp_merged_value = out_merged_ff;

   // Status to the controller
   always_comb begin
      sts.func       = func_ff;
      sts.key_zero   = (key_ff == '0);
      sts.count_full = (count_ff >= CNT_W'(CAPACITY));
      sts.count      = count_ff;
      sts.idx_zero   = (idx_ff == '0);
      sts.rd_key_ge  = (rd_entry.key >= key_ff);
      sts.rd_key_eq  = (rd_entry.key == key_ff);
      sts.rd_key_lt  = (rd_entry.key < key_ff);
      sts.lk_open    = (lo_ff < end_ff);
      sts.out_free   = !out_valid_ff || rsp_ready;
   end

endmodule

@@ rtl/core/skm_controller.sv @@
// Controller state machine of the sorted key map
module skm_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  skm_pkg::sts_type sts,
   output skm_pkg::cmd_type cmd
);
   import skm_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.res_clear = 1'b1;
            case (sts.func)
               FUNC_INSERT: begin
                  if (sts.key_zero) begin
                     state_in = ST_FINISH;
                  end else if (sts.count_full) begin
                     cmd.res_set_full = 1'b1;
                     state_in         = ST_FINISH;
                  end else begin
                     cmd.idx_load = 1'b1;
                     state_in     = ST_INS_CHECK;
                  end
               end
               FUNC_LOOKUP: begin
                  cmd.lk_init = 1'b1;
                  state_in    = ST_LK_CHECK;
               end
               FUNC_CLEAR: begin
                  cmd.count_clear = 1'b1;
                  state_in        = ST_FINISH;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         // Bottom reached: place the new entry, else fetch the entry below the cursor
         ST_INS_CHECK: begin
            if (sts.idx_zero) begin
               cmd.ins_write_new = 1'b1;
               cmd.count_inc     = 1'b1;
               state_in          = ST_FINISH;
            end else begin
               cmd.rd_ins = 1'b1;
               state_in   = ST_INS_MOVE;
            end
         end
         // Shift a greater-or-equal entry up, else the slot is found
         ST_INS_MOVE: begin
            if (sts.rd_key_ge) begin
               cmd.ins_write_old = 1'b1;
               cmd.idx_dec       = 1'b1;
               state_in          = ST_INS_CHECK;
            end else begin
               cmd.ins_write_new = 1'b1;
               cmd.count_inc     = 1'b1;
               state_in          = ST_FINISH;
            end
         end
         ST_LK_CHECK: begin
            if (sts.lk_open) begin
               cmd.rd_lk = 1'b1;
               state_in  = ST_LK_CMP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_LK_CMP: begin
            if (sts.rd_key_eq) begin
               cmd.res_set_hit = 1'b1;
               state_in        = ST_FINISH;
            end else if (sts.rd_key_lt) begin
               cmd.lk_right = 1'b1;
               state_in     = ST_LK_CHECK;
            end else begin
               cmd.lk_left = 1'b1;
               state_in    = ST_LK_CHECK;
            end
         end
         // Hand the result to the output register once it is free
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/sorted_key_map_insert_lookup.sv @@
// Sorted key map top level. Insert shifts S entries up one slot (at most CAPACITY-1), then
// writes the new entry in the freed slot. Lookup is a binary search of P probes (at most
// log2(CAPACITY)+1). Clear, dropped inserts and unused codes go straight to the finish state.
// One item at a time; with the RAM's single registered read port, each shift or probe is a
// read state followed by a compare state. The result waits in an output register while the next
// item is taken. Synchronous reset empties the table and idles the controller; RAM is kept.
`include "assert_macros.svh"

module sorted_key_map_insert_lookup (
   input logic        clock,
   input logic        reset,
   skm_req_if.sink    req_bus,
   skm_rsp_if.source  rsp_bus
);
   import skm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   skm_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   skm_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_func         (req_bus.func),
      .req_key_code     (req_bus.key_code),
      .req_entry_id     (req_bus.entry_id),
      .req_entry_data   (req_bus.entry_data),
      .req_event_param  (req_bus.event_param),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_found        (rsp_bus.found),
      .rsp_table_full   (rsp_bus.table_full),
      .rsp_hit_id       (rsp_bus.hit_id),
      .rsp_hit_data     (rsp_bus.hit_data),
      .rsp_merged_value (rsp_bus.merged_value)
   );

   // Entry count never passes the table size
   `SKM_ASSERT_ALWAYS(a_count_bound, clock, reset, sts.count <= CNT_W'(CAPACITY))

   // One item in flight: no request transfer straight after another
   `SKM_ASSERT_NEXT(a_one_item, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)

   // Count grows only with the write that places a new entry
   `SKM_ASSERT_IMPLIES(a_count_write, clock, reset, cmd.count_inc, cmd.ins_write_new && !cmd.ins_write_old)

endmodule
